### design/pctc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctc_pkg: shared types, constants and functions
// Widths, register codes, reset values and the fixed-point row transform used
// by the point cloud transform and crop core.
// ----------------------------------------------------------------------------
package pctc_pkg;

   localparam int COORD_W        = 16;
   localparam int FRAC_BITS      = 13;
   localparam int ACC_W          = 35;
   localparam int SHIFT_W        = ACC_W - FRAC_BITS;
   localparam int PIDX_W         = 20;
   localparam int KEPT_W         = 21;
   localparam int ROW_W          = 64;
   localparam int BOX_W          = 48;
   localparam int CSR_IDX_W      = 3;
   localparam int DEF_MAX_POINTS = 1048576;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_X    = 3'd0,
      CSR_ROW_Y    = 3'd1,
      CSR_ROW_Z    = 3'd2,
      CSR_BOX_LOW  = 3'd3,
      CSR_BOX_HIGH = 3'd4
   } csr_index_type;

   localparam logic [ROW_W-1:0] ROW_X_RESET    = 64'h0000_0000_0000_2000;
   localparam logic [ROW_W-1:0] ROW_Y_RESET    = 64'h0000_0000_2000_0000;
   localparam logic [ROW_W-1:0] ROW_Z_RESET    = 64'h0000_2000_0000_0000;
   localparam logic [BOX_W-1:0] BOX_LOW_RESET  = 48'hD8F0_D8F0_D8F0;
   localparam logic [BOX_W-1:0] BOX_HIGH_RESET = 48'h2710_2710_2710;

   localparam coord_type COORD_MAX = 16'sh7FFF;
   localparam coord_type COORD_MIN = 16'sh8000;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));

   // Computes one output coordinate: three Q2.13 products, the translation
   // in millimetres, round half up, then saturation to 16 bits.
   function automatic coord_type xform_row(input logic [ROW_W-1:0] row,
                                           input coord_type x,
                                           input coord_type y,
                                           input coord_type z);
      logic signed [ACC_W-1:0]   acc;
      logic signed [SHIFT_W-1:0] sh;
      coord_type                 res;
      acc = ACC_W'($signed(row[15:0])) * ACC_W'(x)
          + ACC_W'($signed(row[31:16])) * ACC_W'(y)
          + ACC_W'($signed(row[47:32])) * ACC_W'(z)
          + (ACC_W'($signed(row[63:48])) <<< FRAC_BITS)
          + ROUND_HALF;
      sh = acc[ACC_W-1:FRAC_BITS];
      if ((&sh[SHIFT_W-1:COORD_W-1]) || !(|sh[SHIFT_W-1:COORD_W-1])) begin
         res = sh[COORD_W-1:0];
      end else if (sh[SHIFT_W-1]) begin
         res = COORD_MIN;
      end else begin
         res = COORD_MAX;
      end
      return res;
   endfunction

endpackage

### design/point_cloud_transform_crop_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_cloud_transform_crop_core: affine transform and box crop of points
// Transforms each depth point by three configured rows, saturates to 16 bits,
// tests it strictly inside a box and reports per-frame index and kept count.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  px, py, pz, frame_end
// rsp       out        rsp_valid/rsp_stall  tx, ty, tz, inside_res, point_index,
//                                           kept_count, last
// csr       in         csr_write            csr_index, csr_wdata
//
// One request per cycle is accepted while req_stall is low; its result passes
// through the input register and then the result register around the
// transform before it is on the outputs.
// Reset is synchronous and clears both valid bits, the counters and the
// configuration to identity transform and a box of +/-10000 mm.
// A stalled result holds while the input register still takes one request.
// ----------------------------------------------------------------------------
module point_cloud_transform_crop_core
   import pctc_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [COORD_W-1:0]   req_px,
   input  logic [COORD_W-1:0]   req_py,
   input  logic [COORD_W-1:0]   req_pz,
   input  logic                 req_frame_end,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [COORD_W-1:0]   rsp_tx,
   output logic [COORD_W-1:0]   rsp_ty,
   output logic [COORD_W-1:0]   rsp_tz,
   output logic                 rsp_inside_res,
   output logic [PIDX_W-1:0]    rsp_point_index,
   output logic [KEPT_W-1:0]    rsp_kept_count,
   output logic                 rsp_last,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ROW_W-1:0]     csr_wdata
);

   localparam int PCNT_W = $clog2(MAX_POINTS);
   localparam int KCNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [PCNT_W-1:0] PNT_LIMIT  = PCNT_W'(MAX_POINTS - 1);
   localparam logic [KCNT_W-1:0] KEPT_LIMIT = KCNT_W'(MAX_POINTS);

   logic [ROW_W-1:0]  row_x_ff, row_y_ff, row_z_ff;
   logic [ROW_W-1:0]  row_x_in, row_y_in, row_z_in;
   logic [BOX_W-1:0]  box_low_ff, box_high_ff;
   logic [BOX_W-1:0]  box_low_in, box_high_in;

   logic              s1_valid_ff, s1_valid_in;
   coord_type         s1_px_ff, s1_py_ff, s1_pz_ff;
   coord_type         s1_px_in, s1_py_in, s1_pz_in;
   logic              s1_fend_ff, s1_fend_in;

   logic [PCNT_W-1:0] point_counter_ff, point_counter_in;
   logic [KCNT_W-1:0] kept_counter_ff, kept_counter_in;

   logic              rsp_valid_ff, rsp_valid_in;
   coord_type         rsp_tx_ff, rsp_ty_ff, rsp_tz_ff;
   coord_type         rsp_tx_in, rsp_ty_in, rsp_tz_in;
   logic              rsp_inside_ff, rsp_inside_in;
   logic [PIDX_W-1:0] rsp_pidx_ff, rsp_pidx_in;
   logic [KEPT_W-1:0] rsp_kept_ff, rsp_kept_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              advance;
   logic              req_take;
   coord_type         t_x, t_y, t_z;
   logic              in_box;
   logic [KCNT_W-1:0] kept_now;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      row_x_in    = row_x_ff;
      row_y_in    = row_y_ff;
      row_z_in    = row_z_ff;
      box_low_in  = box_low_ff;
      box_high_in = box_high_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_X:    row_x_in    = csr_wdata;
            CSR_ROW_Y:    row_y_in    = csr_wdata;
            CSR_ROW_Z:    row_z_in    = csr_wdata;
            CSR_BOX_LOW:  box_low_in  = csr_wdata[BOX_W-1:0];
            CSR_BOX_HIGH: box_high_in = csr_wdata[BOX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = req_take || (s1_valid_ff && !advance);
      s1_px_in    = req_take ? coord_type'(req_px) : s1_px_ff;
      s1_py_in    = req_take ? coord_type'(req_py) : s1_py_ff;
      s1_pz_in    = req_take ? coord_type'(req_pz) : s1_pz_ff;
      s1_fend_in  = req_take ? req_frame_end : s1_fend_ff;
   end

   always_comb begin
      t_x = xform_row(row_x_ff, s1_px_ff, s1_py_ff, s1_pz_ff);
      t_y = xform_row(row_y_ff, s1_px_ff, s1_py_ff, s1_pz_ff);
      t_z = xform_row(row_z_ff, s1_px_ff, s1_py_ff, s1_pz_ff);
      in_box = (t_x > $signed(box_low_ff[15:0]))  && (t_x < $signed(box_high_ff[15:0]))
            && (t_y > $signed(box_low_ff[31:16])) && (t_y < $signed(box_high_ff[31:16]))
            && (t_z > $signed(box_low_ff[47:32])) && (t_z < $signed(box_high_ff[47:32]));
      kept_now = (in_box && (kept_counter_ff < KEPT_LIMIT)) ?
                 kept_counter_ff + 1'b1 : kept_counter_ff;
   end

   always_comb begin
      point_counter_in = point_counter_ff;
      kept_counter_in  = kept_counter_ff;
      if (advance) begin
         if (s1_fend_ff) begin
            point_counter_in = '0;
            kept_counter_in  = '0;
         end else begin
            kept_counter_in = kept_now;
            if (point_counter_ff < PNT_LIMIT) begin
               point_counter_in = point_counter_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);
      rsp_tx_in     = advance ? t_x : rsp_tx_ff;
      rsp_ty_in     = advance ? t_y : rsp_ty_ff;
      rsp_tz_in     = advance ? t_z : rsp_tz_ff;
      rsp_inside_in = advance ? in_box : rsp_inside_ff;
      rsp_pidx_in   = advance ? PIDX_W'(point_counter_ff) : rsp_pidx_ff;
      rsp_kept_in   = advance ? KEPT_W'(kept_now) : rsp_kept_ff;
      rsp_last_in   = advance ? s1_fend_ff : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff         <= ROW_X_RESET;
         row_y_ff         <= ROW_Y_RESET;
         row_z_ff         <= ROW_Z_RESET;
         box_low_ff       <= BOX_LOW_RESET;
         box_high_ff      <= BOX_HIGH_RESET;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         point_counter_ff <= '0;
         kept_counter_ff  <= '0;
      end else begin
         row_x_ff         <= row_x_in;
         row_y_ff         <= row_y_in;
         row_z_ff         <= row_z_in;
         box_low_ff       <= box_low_in;
         box_high_ff      <= box_high_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         point_counter_ff <= point_counter_in;
         kept_counter_ff  <= kept_counter_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_px_ff      <= s1_px_in;
      s1_py_ff      <= s1_py_in;
      s1_pz_ff      <= s1_pz_in;
      s1_fend_ff    <= s1_fend_in;
      rsp_tx_ff     <= rsp_tx_in;
      rsp_ty_ff     <= rsp_ty_in;
      rsp_tz_ff     <= rsp_tz_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_pidx_ff   <= rsp_pidx_in;
      rsp_kept_ff   <= rsp_kept_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tx          = rsp_tx_ff;
   assign rsp_ty          = rsp_ty_ff;
   assign rsp_tz          = rsp_tz_ff;
   assign rsp_inside_res  = rsp_inside_ff;
   assign rsp_point_index = rsp_pidx_ff;
   assign rsp_kept_count  = rsp_kept_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### design/pctc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctc_checker: port-level checks for the transform and crop core
// Watches the result channel for reset behavior, hold under stall, the box
// test against saturated values and the restart of counts after a frame end.
// ----------------------------------------------------------------------------
module pctc_checker
   import pctc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [COORD_W-1:0]   rsp_tx,
   input logic [COORD_W-1:0]   rsp_ty,
   input logic [COORD_W-1:0]   rsp_tz,
   input logic                 rsp_inside_res,
   input logic [PIDX_W-1:0]    rsp_point_index,
   input logic [KEPT_W-1:0]    rsp_kept_count,
   input logic                 rsp_last
);

   logic after_last_ff, after_last_in;

   always_comb begin
      after_last_in = after_last_ff;
      if (rsp_valid && !rsp_stall) begin
         after_last_in = rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_last_ff <= 1'b1;
      end else begin
         after_last_ff <= after_last_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx) && $stable(rsp_ty)
         && $stable(rsp_tz) && $stable(rsp_kept_count) && $stable(rsp_point_index))
      else $error("stalled result changed");

   a_inside_not_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |->
         rsp_tx != COORD_MIN && rsp_tx != COORD_MAX &&
         rsp_ty != COORD_MIN && rsp_ty != COORD_MAX &&
         rsp_tz != COORD_MIN && rsp_tz != COORD_MAX)
      else $error("inside point at a saturated coordinate");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && after_last_ff |->
         rsp_point_index == '0 && rsp_kept_count == KEPT_W'(rsp_inside_res))
      else $error("counts did not restart after frame end");

endmodule

bind point_cloud_transform_crop_core pctc_checker u_pctc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_tx          (rsp_tx),
   .rsp_ty          (rsp_ty),
   .rsp_tz          (rsp_tz),
   .rsp_inside_res  (rsp_inside_res),
   .rsp_point_index (rsp_point_index),
   .rsp_kept_count  (rsp_kept_count),
   .rsp_last        (rsp_last)
);

### sim/pctc_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctc_result_check: result predictor and comparator for the crop core
// Watches the request, result and register ports, predicts each result
// in fixed point from its own copy of the rows, box and frame counters,
// and compares every accepted result field by field in order.
// ----------------------------------------------------------------------------
module pctc_result_check
   import pctc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [COORD_W-1:0]   req_px,
   input  logic [COORD_W-1:0]   req_py,
   input  logic [COORD_W-1:0]   req_pz,
   input  logic                 req_frame_end,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [COORD_W-1:0]   rsp_tx,
   input  logic [COORD_W-1:0]   rsp_ty,
   input  logic [COORD_W-1:0]   rsp_tz,
   input  logic                 rsp_inside_res,
   input  logic [PIDX_W-1:0]    rsp_point_index,
   input  logic [KEPT_W-1:0]    rsp_kept_count,
   input  logic                 rsp_last,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ROW_W-1:0]     csr_wdata,
   output int                   fail_count,
   output int                   pending,
   output int                   results_seen,
   output int                   inside_seen,
   output int                   frames_seen
);

   typedef struct packed {
      logic [COORD_W-1:0] tx;
      logic [COORD_W-1:0] ty;
      logic [COORD_W-1:0] tz;
      logic               hit;
      logic [PIDX_W-1:0]  index;
      logic [KEPT_W-1:0]  kept;
      logic               last;
   } point_result_type;

   point_result_type expected_points[$];
   logic [ROW_W-1:0] rows [3];
   logic [BOX_W-1:0] lower_bounds;
   logic [BOX_W-1:0] upper_bounds;
   int unsigned      point_pos;
   int unsigned      kept_total;
   int               fails;
   int               n_results;
   int               n_inside;
   int               n_frames;

   function automatic longint sext16(input logic [COORD_W-1:0] v);
      return longint'($signed(v));
   endfunction

   function automatic logic [COORD_W-1:0] map_axis(input logic [ROW_W-1:0] row,
                                                   input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y,
                                                   input logic [COORD_W-1:0] z);
      longint sum;
      longint q;
      sum = sext16(row[15:0]) * sext16(x) + sext16(row[31:16]) * sext16(y)
          + sext16(row[47:32]) * sext16(z)
          + (sext16(row[63:48]) <<< FRAC_BITS)
          + (longint'(1) <<< (FRAC_BITS - 1));
      q = sum >>> FRAC_BITS;
      if (q > 32767) begin
         q = 32767;
      end else if (q < -32768) begin
         q = -32768;
      end
      return q[COORD_W-1:0];
   endfunction

   task automatic report_field(input string name, input longint want, input longint seen);
      if (want != seen) begin
         fails++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
   endtask

   always @(posedge clock) begin
      point_result_type   want;
      logic [COORD_W-1:0] mapped [3];
      logic               in_box;
      if (reset) begin
         expected_points.delete();
         rows[0]      = ROW_X_RESET;
         rows[1]      = ROW_Y_RESET;
         rows[2]      = ROW_Z_RESET;
         lower_bounds = BOX_LOW_RESET;
         upper_bounds = BOX_HIGH_RESET;
         point_pos    = 0;
         kept_total   = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ROW_X: begin
                  rows[0] = csr_wdata;
               end
               CSR_ROW_Y: begin
                  rows[1] = csr_wdata;
               end
               CSR_ROW_Z: begin
                  rows[2] = csr_wdata;
               end
               CSR_BOX_LOW: begin
                  lower_bounds = csr_wdata[BOX_W-1:0];
               end
               CSR_BOX_HIGH: begin
                  upper_bounds = csr_wdata[BOX_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            in_box = 1'b1;
            for (int k = 0; k < 3; k++) begin
               mapped[k] = map_axis(rows[k], req_px, req_py, req_pz);
               if (!($signed(mapped[k]) > $signed(lower_bounds[16*k +: 16]) &&
                     $signed(mapped[k]) < $signed(upper_bounds[16*k +: 16]))) begin
                  in_box = 1'b0;
               end
            end
            if (in_box && kept_total < DEF_MAX_POINTS) begin
               kept_total++;
            end
            want.tx    = mapped[0];
            want.ty    = mapped[1];
            want.tz    = mapped[2];
            want.hit   = in_box;
            want.index = point_pos[PIDX_W-1:0];
            want.kept  = kept_total[KEPT_W-1:0];
            want.last  = req_frame_end;
            expected_points.push_back(want);
            if (req_frame_end) begin
               point_pos  = 0;
               kept_total = 0;
            end else if (point_pos < DEF_MAX_POINTS - 1) begin
               point_pos++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (rsp_inside_res) begin
               n_inside++;
            end
            if (rsp_last) begin
               n_frames++;
            end
            if (expected_points.size() == 0) begin
               fails++;
               $display("%0t: result arrived with no request outstanding", $time);
            end else begin
               want = expected_points.pop_front();
               report_field("tx", sext16(want.tx), sext16(rsp_tx));
               report_field("ty", sext16(want.ty), sext16(rsp_ty));
               report_field("tz", sext16(want.tz), sext16(rsp_tz));
               report_field("inside_res", longint'(want.hit), longint'(rsp_inside_res));
               report_field("point_index", longint'(want.index), longint'(rsp_point_index));
               report_field("kept_count", longint'(want.kept), longint'(rsp_kept_count));
               report_field("last", longint'(want.last), longint'(rsp_last));
            end
         end
      end
      fail_count   <= fails;
      pending      <= expected_points.size();
      results_seen <= n_results;
      inside_seen  <= n_inside;
      frames_seen  <= n_frames;
   end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the point cloud transform and crop core
// Drives directed corner points and random frames of points through the core
// under several register settings, with random gaps on the request side and
// random stalls on the result side, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module testbench
   import pctc_pkg::*;
();

   localparam int IDLE_PCT      = 19;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_POINTS  = 150;
   localparam int STEADY_PHASE  = 2;
   localparam int DRAIN_LIMIT   = 20000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_C = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [COORD_W-1:0]   req_px = '0;
   logic [COORD_W-1:0]   req_py = '0;
   logic [COORD_W-1:0]   req_pz = '0;
   logic                 req_frame_end = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COORD_W-1:0]   rsp_tx;
   logic [COORD_W-1:0]   rsp_ty;
   logic [COORD_W-1:0]   rsp_tz;
   logic                 rsp_inside_res;
   logic [PIDX_W-1:0]    rsp_point_index;
   logic [KEPT_W-1:0]    rsp_kept_count;
   logic                 rsp_last;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ROW_W-1:0]     csr_wdata = '0;

   int fail_count;
   int pending;
   int results_seen;
   int inside_seen;
   int frames_seen;
   int settings_used;
   bit steady = 1'b0;

   always #1 clock = ~clock;

   point_cloud_transform_crop_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_px          (req_px),
      .req_py          (req_py),
      .req_pz          (req_pz),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx          (rsp_tx),
      .rsp_ty          (rsp_ty),
      .rsp_tz          (rsp_tz),
      .rsp_inside_res  (rsp_inside_res),
      .rsp_point_index (rsp_point_index),
      .rsp_kept_count  (rsp_kept_count),
      .rsp_last        (rsp_last),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   pctc_result_check result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_px          (req_px),
      .req_py          (req_py),
      .req_pz          (req_pz),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx          (rsp_tx),
      .rsp_ty          (rsp_ty),
      .rsp_tz          (rsp_tz),
      .rsp_inside_res  (rsp_inside_res),
      .rsp_point_index (rsp_point_index),
      .rsp_kept_count  (rsp_kept_count),
      .rsp_last        (rsp_last),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_seen    (results_seen),
      .inside_seen     (inside_seen),
      .frames_seen     (frames_seen)
   );

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
   end

   task automatic push_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z, input logic last_point);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_px        <= x;
      req_py        <= y;
      req_pz        <= z;
      req_frame_end <= last_point;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [ROW_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [COORD_W-1:0] rand_coord();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         return 16'(int'($urandom_range(0, 24000)) - 12000);
      end else if (pick < 8) begin
         return 16'($urandom);
      end else if (pick == 8) begin
         case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
         endcase
      end
      return 16'(int'($urandom_range(0, 32)) - 16);
   endfunction

   function automatic logic [ROW_W-1:0] rand_row();
      logic [ROW_W-1:0] row;
      if ($urandom_range(0, 5) == 0) begin
         row = {$urandom, $urandom};
      end else begin
         row[15:0]  = 16'(int'($urandom_range(0, 16384)) - 8192);
         row[31:16] = 16'(int'($urandom_range(0, 16384)) - 8192);
         row[47:32] = 16'(int'($urandom_range(0, 16384)) - 8192);
         row[63:48] = 16'(int'($urandom_range(0, 4000)) - 2000);
      end
      return row;
   endfunction

   function automatic logic [ROW_W-1:0] rand_bounds(input bit upper);
      logic [ROW_W-1:0] bounds;
      bounds = '0;
      if ($urandom_range(0, 5) == 0) begin
         bounds = {16'($urandom), $urandom};
      end else begin
         for (int k = 0; k < 3; k++) begin
            bounds[16*k +: 16] = upper ? 16'($urandom_range(0, 15000))
                                       : 16'(-int'($urandom_range(0, 15000)));
         end
      end
      return bounds;
   endfunction

   initial begin
      int frame_len;
      int in_frame;
      int drain_wait;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      settings_used = 1;

      // Identity rows and the default box: boundaries and coordinate extremes.
      push_point(16'd0, 16'd0, 16'd0, 1'b0);
      push_point(16'd9999, -16'sd9999, 16'd9999, 1'b0);
      push_point(16'd10000, 16'd0, 16'd0, 1'b0);
      push_point(-16'sd10000, 16'd0, 16'd0, 1'b0);
      push_point(16'd0, -16'sd10000, 16'd0, 1'b0);
      push_point(16'd0, 16'd0, 16'd10000, 1'b0);
      push_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
      push_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
      push_point(16'hFFFF, 16'd1, 16'hFFFF, 1'b1);
      push_point(16'd5, 16'd6, 16'd7, 1'b1);
      settle();

      // Full-scale rows drive saturation; half-scale row checks round half up.
      write_reg(CSR_ROW_X, 64'h7FFF_7FFF_7FFF_7FFF);
      write_reg(CSR_ROW_Y, 64'h8000_8000_8000_8000);
      write_reg(CSR_ROW_Z, 64'h0000_0000_1000_0000);
      write_reg(CSR_BOX_LOW, 64'h0000_8000_8000_8000);
      write_reg(CSR_BOX_HIGH, 64'h0000_7FFF_7FFF_7FFF);
      settings_used++;
      push_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
      push_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
      push_point(16'd1, 16'd1, 16'd1, 1'b0);
      push_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      push_point(16'd3, -16'sd3, 16'd0, 1'b0);
      push_point(16'd0, 16'd0, 16'd0, 1'b1);
      settle();

      // A degenerate box keeps every point out; spare indexes must be ignored.
      write_reg(CSR_ROW_X, ROW_X_RESET);
      write_reg(CSR_ROW_Y, ROW_Y_RESET);
      write_reg(CSR_ROW_Z, ROW_Z_RESET);
      write_reg(CSR_BOX_LOW, 64'h0000_0000_0000_0000);
      write_reg(CSR_BOX_HIGH, 64'h0000_0000_0000_0000);
      write_reg(CSR_SPARE_A, '1);
      write_reg(CSR_SPARE_B, '1);
      write_reg(CSR_SPARE_C, '1);
      settings_used++;
      push_point(16'd0, 16'd0, 16'd0, 1'b0);
      push_point(16'd1, 16'd1, 16'd1, 1'b1);
      settle();
      write_reg(CSR_BOX_LOW, 64'h0000_0064_0064_0064);
      write_reg(CSR_BOX_HIGH, 64'h0000_FF9C_FF9C_FF9C);
      settings_used++;
      push_point(16'd0, 16'd0, 16'd0, 1'b0);
      push_point(16'd50, -16'sd50, 16'd0, 1'b1);
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_reg(CSR_ROW_X, rand_row());
         write_reg(CSR_ROW_Y, rand_row());
         write_reg(CSR_ROW_Z, rand_row());
         write_reg(CSR_BOX_LOW, rand_bounds(1'b0));
         write_reg(CSR_BOX_HIGH, rand_bounds(1'b1));
         if (phase % 2 == 1) begin
            write_reg(CSR_SPARE_A + CSR_IDX_W'($urandom_range(0, 2)), {$urandom, $urandom});
         end
         settings_used++;
         steady = (phase == STEADY_PHASE);
         frame_len = $urandom_range(1, 40);
         in_frame = 0;
         for (int n = 0; n < PHASE_POINTS; n++) begin
            in_frame++;
            push_point(rand_coord(), rand_coord(), rand_coord(),
                       (in_frame == frame_len) || ($urandom_range(0, 49) == 0));
            if (req_frame_end) begin
               frame_len = $urandom_range(1, 40);
               in_frame = 0;
            end
         end
         steady = 1'b0;
         settle();
      end

      req_valid <= 1'b0;
      drain_wait = 0;
      while (pending != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (8) @(posedge clock);
      $display("Run covered %0d points in %0d frames over %0d register settings,",
               results_seen, frames_seen, settings_used);
      $display("of which %0d landed inside the crop box.", inside_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Timed out with %0d results still outstanding.", pending);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
